FILE: rtl/fte_pkg.sv
package fte_pkg;

	localparam int GUARD_BITS    = 8;
	localparam int HEADROOM_BITS = 4;
	localparam int ANGLE_W       = 32;
	localparam int ZW            = 34;
	localparam int OUT_W         = 16;
	localparam int THR_W         = 10;
	localparam int GAIN_SHIFT    = 20;
	localparam int MAX_STAGES    = 32;

	localparam logic [19:0]        GAIN_COMP = 20'd636750;
	localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [ANGLE_W-1:0] OUT_ROUND = 32'h0000_8000;

	// register index, taken from paddr[2]
	localparam logic [0:0] REG_NEAR_ZERO = 1'b0;

	// atan(2^-i) in binary-angle units, 2^32 per turn
	localparam logic [ANGLE_W-1:0] ATAN_UNITS [0:MAX_STAGES-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage

FILE: rtl/fte_if.sv
interface fte_frame_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] first_x;
	logic signed [W-1:0] first_y;
	logic signed [W-1:0] first_z;
	logic signed [W-1:0] second_x;
	logic signed [W-1:0] second_y;
	logic signed [W-1:0] second_z;

	modport source (
		output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		input  ready
	);
	modport sink (
		input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
		output ready
	);
endinterface

interface fte_angle_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] angle_about_x;
	logic signed [15:0] angle_about_y;
	logic signed [15:0] angle_about_z;

	modport source (
		output valid, angle_about_x, angle_about_y, angle_about_z,
		input  ready
	);
	modport sink (
		input  valid, angle_about_x, angle_about_y, angle_about_z,
		output ready
	);
endinterface

FILE: rtl/fte_vec_cell.sv
module fte_vec_cell import fte_pkg::*; #(
	parameter int IW    = 28,
	parameter int SHIFT = 0,
	parameter int SW    = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                up_valid,
	input  logic signed [IW-1:0] up_a,
	input  logic signed [IW-1:0] up_b,
	input  logic [ANGLE_W-1:0]  up_z,
	input  logic [SW-1:0]       up_side,
	output logic                dn_valid,
	output logic signed [IW-1:0] dn_a,
	output logic signed [IW-1:0] dn_b,
	output logic [ANGLE_W-1:0]  dn_z,
	output logic [SW-1:0]       dn_side
);

	logic                valid_q;
	logic signed [IW-1:0] a_q, b_q;
	logic [ANGLE_W-1:0]  z_q;
	logic [SW-1:0]       side_q;
	logic signed [IW-1:0] da, db, a_nx, b_nx;
	logic [ANGLE_W-1:0]  z_nx;

	always_comb begin
		da = up_b >>> SHIFT;
		db = up_a >>> SHIFT;
		if (!up_b[IW-1]) begin
			a_nx = up_a + da;
			b_nx = up_b - db;
			z_nx = up_z + ATAN_UNITS[SHIFT];
		end else begin
			a_nx = up_a - da;
			b_nx = up_b + db;
			z_nx = up_z - ATAN_UNITS[SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_q    <= a_nx;
			b_q    <= b_nx;
			z_q    <= z_nx;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_a     = a_q;
	assign dn_b     = b_q;
	assign dn_z     = z_q;
	assign dn_side  = side_q;

endmodule

FILE: rtl/fte_rot_cell.sv
module fte_rot_cell import fte_pkg::*; #(
	parameter int IW    = 28,
	parameter int SHIFT = 0,
	parameter int SW    = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 up_valid,
	input  logic signed [IW-1:0] up_a0,
	input  logic signed [IW-1:0] up_b0,
	input  logic signed [IW-1:0] up_a1,
	input  logic signed [IW-1:0] up_b1,
	input  logic [1:0]           up_en,
	input  logic signed [ZW-1:0] up_z,
	input  logic [SW-1:0]        up_side,
	output logic                 dn_valid,
	output logic signed [IW-1:0] dn_a0,
	output logic signed [IW-1:0] dn_b0,
	output logic signed [IW-1:0] dn_a1,
	output logic signed [IW-1:0] dn_b1,
	output logic [1:0]           dn_en,
	output logic signed [ZW-1:0] dn_z,
	output logic [SW-1:0]        dn_side
);

	localparam logic signed [ZW-1:0] STEP = $signed({2'b00, ATAN_UNITS[SHIFT]});

	logic                 valid_q;
	logic signed [IW-1:0] a0_q, b0_q, a1_q, b1_q;
	logic [1:0]           en_q;
	logic signed [ZW-1:0] z_q;
	logic [SW-1:0]        side_q;
	logic signed [IW-1:0] a0_nx, b0_nx, a1_nx, b1_nx;
	logic signed [ZW-1:0] z_nx;
	logic                 ccw;

	function automatic logic [2*IW-1:0] turn(input logic signed [IW-1:0] a,
			input logic signed [IW-1:0] b, input logic dir, input logic en);
		logic signed [IW-1:0] da, db;
		da = b >>> SHIFT;
		db = a >>> SHIFT;
		if (!en) begin
			return {a, b};
		end else if (dir) begin
			return {a - da, b + db};
		end else begin
			return {a + da, b - db};
		end
	endfunction

	always_comb begin
		ccw = !up_z[ZW-1];
		{a0_nx, b0_nx} = turn(up_a0, up_b0, ccw, up_en[0]);
		{a1_nx, b1_nx} = turn(up_a1, up_b1, ccw, up_en[1]);
		z_nx = ccw ? up_z - STEP : up_z + STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a0_q   <= a0_nx;
			b0_q   <= b0_nx;
			a1_q   <= a1_nx;
			b1_q   <= b1_nx;
			en_q   <= up_en;
			z_q    <= z_nx;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_a0    = a0_q;
	assign dn_b0    = b0_q;
	assign dn_a1    = a1_q;
	assign dn_b1    = b1_q;
	assign dn_en    = en_q;
	assign dn_z     = z_q;
	assign dn_side  = side_q;

endmodule

FILE: rtl/frame_to_euler_angles.sv
// throughput: one frame per cycle while the output is not stalled; every CORDIC iteration is its own register stage
// a stalled output holds the whole chain in place
// arst_n clears the valid bits of every stage and the threshold register to 0
module frame_to_euler_angles import fte_pkg::*; #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	fte_frame_if.sink          frame,
	fte_angle_if.source        angles,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CW = COMPONENT_WIDTH;
	localparam int IW = CW + GUARD_BITS + HEADROOM_BITS;
	localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	localparam int GW = IW + GAIN_SHIFT + 1;

	localparam logic signed [GW-1:0] GAIN_K     = GW'(GAIN_COMP);
	localparam logic signed [GW-1:0] GAIN_ROUND = GW'(1) << (GAIN_SHIFT - 1);
	localparam logic signed [ZW-1:0] QUARTER_Z  = ZW'(1) << (ANGLE_W - 2);
	localparam logic signed [ZW-1:0] HALF_Z     = ZW'(1) << (ANGLE_W - 1);

	typedef struct packed {
		logic signed [IW-1:0] fx;
		logic signed [IW-1:0] fy;
		logic signed [IW-1:0] fz;
		logic signed [IW-1:0] sx;
		logic signed [IW-1:0] sy;
		logic signed [IW-1:0] sz;
		logic [ANGLE_W-1:0]   ang_z;
		logic [ANGLE_W-1:0]   ang_y;
		logic                 und_z;
		logic                 und_y;
		logic                 und_x;
	} frame_t;

	localparam int FW = $bits(frame_t);

	function automatic logic signed [IW-1:0] load(input logic signed [CW-1:0] v);
		return {{HEADROOM_BITS{v[CW-1]}}, v, {GUARD_BITS{1'b0}}};
	endfunction

	function automatic logic nz(input logic signed [IW-1:0] a, input logic signed [IW-1:0] b,
			input logic [THR_W-1:0] thr);
		logic [IW-1:0]            ma, mb;
		logic [IW-GUARD_BITS-1:0] t;
		ma = a[IW-1] ? IW'(-a) : a;
		mb = b[IW-1] ? IW'(-b) : b;
		t  = (IW - GUARD_BITS)'(thr);
		return (ma[IW-1:GUARD_BITS] <= t) && (mb[IW-1:GUARD_BITS] <= t);
	endfunction

	function automatic logic [2*IW+ANGLE_W-1:0] vec_start(input logic signed [IW-1:0] a,
			input logic signed [IW-1:0] b);
		if (a[IW-1]) begin
			return {IW'(-a), IW'(-b), HALF_TURN};
		end else begin
			return {a, b, {ANGLE_W{1'b0}}};
		end
	endfunction

	function automatic logic [ZW:0] rot_start(input logic [ANGLE_W-1:0] theta);
		logic signed [ZW-1:0] zs;
		logic                 flip;
		zs   = ZW'($signed(theta));
		flip = (zs > QUARTER_Z) || (zs < -QUARTER_Z);
		if (!flip) begin
			return {1'b0, zs};
		end else if (zs > 0) begin
			return {1'b1, ZW'(zs - HALF_Z)};
		end else begin
			return {1'b1, ZW'(zs + HALF_Z)};
		end
	endfunction

	function automatic logic signed [IW-1:0] gain(input logic signed [IW-1:0] a);
		logic signed [GW-1:0] p;
		p = GW'(a) * GAIN_K + GAIN_ROUND;
		return p[IW+GAIN_SHIFT-1:GAIN_SHIFT];
	endfunction

	function automatic logic [OUT_W-1:0] out_angle(input logic [ANGLE_W-1:0] z, input logic und);
		logic [ANGLE_W-1:0] r;
		r = z + OUT_ROUND;
		return und ? '0 : r[ANGLE_W-1:ANGLE_W-OUT_W];
	endfunction

	// configuration
	logic [THR_W-1:0] thr_q;
	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == REG_NEAR_ZERO) ? {{(32 - THR_W){1'b0}}, thr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wr && paddr[2:2] == REG_NEAR_ZERO) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// flow control
	logic out_valid_q;
	logic adv;

	assign adv         = !out_valid_q || angles.ready;
	assign frame.ready = adv;

	// chain wiring
	logic                 v1_valid [0:NS];
	logic signed [IW-1:0] v1_a     [0:NS];
	logic signed [IW-1:0] v1_b     [0:NS];
	logic [ANGLE_W-1:0]   v1_z     [0:NS];
	logic [FW-1:0]        v1_side  [0:NS];
	logic                 v2_valid [0:NS];
	logic signed [IW-1:0] v2_a     [0:NS];
	logic signed [IW-1:0] v2_b     [0:NS];
	logic [ANGLE_W-1:0]   v2_z     [0:NS];
	logic [FW-1:0]        v2_side  [0:NS];
	logic                 v3_valid [0:NS];
	logic signed [IW-1:0] v3_a     [0:NS];
	logic signed [IW-1:0] v3_b     [0:NS];
	logic [ANGLE_W-1:0]   v3_z     [0:NS];
	logic [FW-1:0]        v3_side  [0:NS];
	logic                 r1_valid [0:NS];
	logic signed [IW-1:0] r1_a0    [0:NS];
	logic signed [IW-1:0] r1_b0    [0:NS];
	logic signed [IW-1:0] r1_a1    [0:NS];
	logic signed [IW-1:0] r1_b1    [0:NS];
	logic [1:0]           r1_en    [0:NS];
	logic signed [ZW-1:0] r1_z     [0:NS];
	logic [FW-1:0]        r1_side  [0:NS];
	logic                 r2_valid [0:NS];
	logic signed [IW-1:0] r2_a0    [0:NS];
	logic signed [IW-1:0] r2_b0    [0:NS];
	logic signed [IW-1:0] r2_a1    [0:NS];
	logic signed [IW-1:0] r2_b1    [0:NS];
	logic [1:0]           r2_en    [0:NS];
	logic signed [ZW-1:0] r2_z     [0:NS];
	logic [FW-1:0]        r2_side  [0:NS];

	// head registers of each phase
	logic                 v1_valid_q, v2_valid_q, v3_valid_q;
	logic signed [IW-1:0] v1_a_q, v1_b_q, v2_a_q, v2_b_q, v3_a_q, v3_b_q;
	logic [ANGLE_W-1:0]   v1_z_q, v2_z_q, v3_z_q;
	frame_t               v1_side_q, v2_side_q, v3_side_q;
	logic                 r1_valid_q, r2_valid_q;
	logic signed [IW-1:0] r1_a0_q, r1_b0_q, r1_a1_q, r1_b1_q;
	logic signed [IW-1:0] r2_a0_q, r2_b0_q, r2_a1_q, r2_b1_q;
	logic [1:0]           r1_en_q, r2_en_q;
	logic signed [ZW-1:0] r1_z_q, r2_z_q;
	frame_t               r1_side_q, r2_side_q;
	logic                 g1_valid_q, g2_valid_q;
	frame_t               g1_frame_q, g2_frame_q;
	logic [OUT_W-1:0]     ax_q, ay_q, az_q;

	// next values of the head registers
	frame_t               in_f, r1_f, g1_f, v2_f, r2_f, g2_f, v3_f, e_f;
	logic signed [IW-1:0] v1_a_nx, v1_b_nx, v2_a_nx, v2_b_nx, v3_a_nx, v3_b_nx;
	logic [ANGLE_W-1:0]   v1_z_nx, v2_z_nx, v3_z_nx, t2;
	logic                 flip1, flip2;
	logic signed [ZW-1:0] r1_z_nx, r2_z_nx;
	logic [1:0]           r1_en_nx, r2_en_nx;
	logic signed [IW-1:0] r1_a0_nx, r1_b0_nx, r1_a1_nx, r1_b1_nx;
	logic signed [IW-1:0] r2_a0_nx, r2_b0_nx, r2_a1_nx, r2_b1_nx;

	always_comb begin
		// about z: vector on (fx, fy)
		in_f       = '0;
		in_f.fx    = load(frame.first_x);
		in_f.fy    = load(frame.first_y);
		in_f.fz    = load(frame.first_z);
		in_f.sx    = load(frame.second_x);
		in_f.sy    = load(frame.second_y);
		in_f.sz    = load(frame.second_z);
		in_f.und_z = nz(in_f.fx, in_f.fy, thr_q);
		{v1_a_nx, v1_b_nx, v1_z_nx} = vec_start(in_f.fx, in_f.fy);

		// rotate back about z
		r1_f       = frame_t'(v1_side[NS]);
		r1_f.ang_z = v1_z[NS];
		{flip1, r1_z_nx} = rot_start(ANGLE_W'(0) - v1_z[NS]);
		r1_en_nx[0] = !r1_f.und_z && !nz(r1_f.fx, r1_f.fy, thr_q);
		r1_en_nx[1] = !r1_f.und_z && !nz(r1_f.sx, r1_f.sy, thr_q);
		r1_a0_nx = (flip1 && r1_en_nx[0]) ? IW'(-r1_f.fx) : r1_f.fx;
		r1_b0_nx = (flip1 && r1_en_nx[0]) ? IW'(-r1_f.fy) : r1_f.fy;
		r1_a1_nx = (flip1 && r1_en_nx[1]) ? IW'(-r1_f.sx) : r1_f.sx;
		r1_b1_nx = (flip1 && r1_en_nx[1]) ? IW'(-r1_f.sy) : r1_f.sy;

		g1_f    = frame_t'(r1_side[NS]);
		g1_f.fx = r1_en[NS][0] ? gain(r1_a0[NS]) : r1_a0[NS];
		g1_f.fy = r1_en[NS][0] ? gain(r1_b0[NS]) : r1_b0[NS];
		g1_f.sx = r1_en[NS][1] ? gain(r1_a1[NS]) : r1_a1[NS];
		g1_f.sy = r1_en[NS][1] ? gain(r1_b1[NS]) : r1_b1[NS];

		// about y: vector on (fx, fz)
		v2_f       = g1_frame_q;
		v2_f.und_y = nz(v2_f.fx, v2_f.fz, thr_q);
		{v2_a_nx, v2_b_nx, v2_z_nx} = vec_start(v2_f.fx, v2_f.fz);

		// rotate back about y
		r2_f       = frame_t'(v2_side[NS]);
		t2         = ANGLE_W'(0) - v2_z[NS];
		r2_f.ang_y = t2;
		{flip2, r2_z_nx} = rot_start(t2);
		r2_en_nx[0] = !r2_f.und_y && !nz(r2_f.fx, r2_f.fz, thr_q);
		r2_en_nx[1] = !r2_f.und_y && !nz(r2_f.sx, r2_f.sz, thr_q);
		r2_a0_nx = (flip2 && r2_en_nx[0]) ? IW'(-r2_f.fx) : r2_f.fx;
		r2_b0_nx = (flip2 && r2_en_nx[0]) ? IW'(-r2_f.fz) : r2_f.fz;
		r2_a1_nx = (flip2 && r2_en_nx[1]) ? IW'(-r2_f.sx) : r2_f.sx;
		r2_b1_nx = (flip2 && r2_en_nx[1]) ? IW'(-r2_f.sz) : r2_f.sz;

		g2_f    = frame_t'(r2_side[NS]);
		g2_f.fx = r2_en[NS][0] ? gain(r2_a0[NS]) : r2_a0[NS];
		g2_f.fz = r2_en[NS][0] ? gain(r2_b0[NS]) : r2_b0[NS];
		g2_f.sx = r2_en[NS][1] ? gain(r2_a1[NS]) : r2_a1[NS];
		g2_f.sz = r2_en[NS][1] ? gain(r2_b1[NS]) : r2_b1[NS];

		// about x: vector on (sy, sz)
		v3_f       = g2_frame_q;
		v3_f.und_x = nz(v3_f.sy, v3_f.sz, thr_q);
		{v3_a_nx, v3_b_nx, v3_z_nx} = vec_start(v3_f.sy, v3_f.sz);

		e_f = frame_t'(v3_side[NS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_valid_q  <= 1'b0;
			r1_valid_q  <= 1'b0;
			g1_valid_q  <= 1'b0;
			v2_valid_q  <= 1'b0;
			r2_valid_q  <= 1'b0;
			g2_valid_q  <= 1'b0;
			v3_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v1_valid_q  <= frame.valid;
			r1_valid_q  <= v1_valid[NS];
			g1_valid_q  <= r1_valid[NS];
			v2_valid_q  <= g1_valid_q;
			r2_valid_q  <= v2_valid[NS];
			g2_valid_q  <= r2_valid[NS];
			v3_valid_q  <= g2_valid_q;
			out_valid_q <= v3_valid[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v1_a_q     <= v1_a_nx;
			v1_b_q     <= v1_b_nx;
			v1_z_q     <= v1_z_nx;
			v1_side_q  <= in_f;
			r1_a0_q    <= r1_a0_nx;
			r1_b0_q    <= r1_b0_nx;
			r1_a1_q    <= r1_a1_nx;
			r1_b1_q    <= r1_b1_nx;
			r1_en_q    <= r1_en_nx;
			r1_z_q     <= r1_z_nx;
			r1_side_q  <= r1_f;
			g1_frame_q <= g1_f;
			v2_a_q     <= v2_a_nx;
			v2_b_q     <= v2_b_nx;
			v2_z_q     <= v2_z_nx;
			v2_side_q  <= v2_f;
			r2_a0_q    <= r2_a0_nx;
			r2_b0_q    <= r2_b0_nx;
			r2_a1_q    <= r2_a1_nx;
			r2_b1_q    <= r2_b1_nx;
			r2_en_q    <= r2_en_nx;
			r2_z_q     <= r2_z_nx;
			r2_side_q  <= r2_f;
			g2_frame_q <= g2_f;
			v3_a_q     <= v3_a_nx;
			v3_b_q     <= v3_b_nx;
			v3_z_q     <= v3_z_nx;
			v3_side_q  <= v3_f;
			ax_q       <= out_angle(v3_z[NS], e_f.und_x);
			ay_q       <= out_angle(e_f.ang_y, e_f.und_y);
			az_q       <= out_angle(e_f.ang_z, e_f.und_z);
		end
	end

	assign v1_valid[0] = v1_valid_q;
	assign v1_a[0]     = v1_a_q;
	assign v1_b[0]     = v1_b_q;
	assign v1_z[0]     = v1_z_q;
	assign v1_side[0]  = v1_side_q;
	assign v2_valid[0] = v2_valid_q;
	assign v2_a[0]     = v2_a_q;
	assign v2_b[0]     = v2_b_q;
	assign v2_z[0]     = v2_z_q;
	assign v2_side[0]  = v2_side_q;
	assign v3_valid[0] = v3_valid_q;
	assign v3_a[0]     = v3_a_q;
	assign v3_b[0]     = v3_b_q;
	assign v3_z[0]     = v3_z_q;
	assign v3_side[0]  = v3_side_q;
	assign r1_valid[0] = r1_valid_q;
	assign r1_a0[0]    = r1_a0_q;
	assign r1_b0[0]    = r1_b0_q;
	assign r1_a1[0]    = r1_a1_q;
	assign r1_b1[0]    = r1_b1_q;
	assign r1_en[0]    = r1_en_q;
	assign r1_z[0]     = r1_z_q;
	assign r1_side[0]  = r1_side_q;
	assign r2_valid[0] = r2_valid_q;
	assign r2_a0[0]    = r2_a0_q;
	assign r2_b0[0]    = r2_b0_q;
	assign r2_a1[0]    = r2_a1_q;
	assign r2_b1[0]    = r2_b1_q;
	assign r2_en[0]    = r2_en_q;
	assign r2_z[0]     = r2_z_q;
	assign r2_side[0]  = r2_side_q;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		fte_vec_cell #(.IW(IW), .SHIFT(k), .SW(FW)) u_v1 (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.up_valid(v1_valid[k]), .up_a(v1_a[k]), .up_b(v1_b[k]),
			.up_z(v1_z[k]), .up_side(v1_side[k]),
			.dn_valid(v1_valid[k+1]), .dn_a(v1_a[k+1]), .dn_b(v1_b[k+1]),
			.dn_z(v1_z[k+1]), .dn_side(v1_side[k+1])
		);
		fte_rot_cell #(.IW(IW), .SHIFT(k), .SW(FW)) u_r1 (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.up_valid(r1_valid[k]), .up_a0(r1_a0[k]), .up_b0(r1_b0[k]),
			.up_a1(r1_a1[k]), .up_b1(r1_b1[k]), .up_en(r1_en[k]),
			.up_z(r1_z[k]), .up_side(r1_side[k]),
			.dn_valid(r1_valid[k+1]), .dn_a0(r1_a0[k+1]), .dn_b0(r1_b0[k+1]),
			.dn_a1(r1_a1[k+1]), .dn_b1(r1_b1[k+1]), .dn_en(r1_en[k+1]),
			.dn_z(r1_z[k+1]), .dn_side(r1_side[k+1])
		);
		fte_vec_cell #(.IW(IW), .SHIFT(k), .SW(FW)) u_v2 (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.up_valid(v2_valid[k]), .up_a(v2_a[k]), .up_b(v2_b[k]),
			.up_z(v2_z[k]), .up_side(v2_side[k]),
			.dn_valid(v2_valid[k+1]), .dn_a(v2_a[k+1]), .dn_b(v2_b[k+1]),
			.dn_z(v2_z[k+1]), .dn_side(v2_side[k+1])
		);
		fte_rot_cell #(.IW(IW), .SHIFT(k), .SW(FW)) u_r2 (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.up_valid(r2_valid[k]), .up_a0(r2_a0[k]), .up_b0(r2_b0[k]),
			.up_a1(r2_a1[k]), .up_b1(r2_b1[k]), .up_en(r2_en[k]),
			.up_z(r2_z[k]), .up_side(r2_side[k]),
			.dn_valid(r2_valid[k+1]), .dn_a0(r2_a0[k+1]), .dn_b0(r2_b0[k+1]),
			.dn_a1(r2_a1[k+1]), .dn_b1(r2_b1[k+1]), .dn_en(r2_en[k+1]),
			.dn_z(r2_z[k+1]), .dn_side(r2_side[k+1])
		);
		fte_vec_cell #(.IW(IW), .SHIFT(k), .SW(FW)) u_v3 (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.up_valid(v3_valid[k]), .up_a(v3_a[k]), .up_b(v3_b[k]),
			.up_z(v3_z[k]), .up_side(v3_side[k]),
			.dn_valid(v3_valid[k+1]), .dn_a(v3_a[k+1]), .dn_b(v3_b[k+1]),
			.dn_z(v3_z[k+1]), .dn_side(v3_side[k+1])
		);
	end

	assign angles.valid         = out_valid_q;
	assign angles.angle_about_x = ax_q;
	assign angles.angle_about_y = ay_q;
	assign angles.angle_about_z = az_q;

endmodule

FILE: rtl/fte_checker.sv
module fte_checker import fte_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_ready,
	input logic        angles_valid,
	input logic        angles_ready,
	input logic [15:0] angle_about_x,
	input logic [15:0] angle_about_y,
	input logic [15:0] angle_about_z,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	logic thr_wr;

	assign thr_wr = psel && penable && pwrite && (paddr[2:2] == REG_NEAR_ZERO);

	// result held until transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && !angles_ready |=> angles_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && !angles_ready |=> $stable(angle_about_x) && $stable(angle_about_y)
			&& $stable(angle_about_z))
		else $error("result changed while stalled");

	// input side stalls only behind a waiting result
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ready == (!angles_valid || angles_ready))
		else $error("input ready does not follow output stall");

	// threshold readback
	a_thr_read: assert property (@(posedge clk) disable iff (!arst_n)
		thr_wr |=> paddr[2:2] != REG_NEAR_ZERO
			|| prdata == {{(32 - THR_W){1'b0}}, $past(pwdata[THR_W-1:0])})
		else $error("threshold readback mismatch");

endmodule

bind frame_to_euler_angles fte_checker u_fte_checker (
	.clk(clk),
	.arst_n(arst_n),
	.frame_ready(frame.ready),
	.angles_valid(angles.valid),
	.angles_ready(angles.ready),
	.angle_about_x(angles.angle_about_x),
	.angle_about_y(angles.angle_about_y),
	.angle_about_z(angles.angle_about_z),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);

FILE: tb/tb_frame_to_euler_angles.sv
`timescale 1ns / 1ps

module tb_frame_to_euler_angles;
	import fte_pkg::*;

	localparam int STAGES  = 16;
	localparam int LATENCY = 5 * STAGES + 8;
	localparam int WD_LIMIT = 5000;

	typedef struct packed {
		logic signed [15:0] fx, fy, fz, sx, sy, sz;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] ax, ay, az;
	} euler_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	fte_frame_if #(.W(16)) frame ();
	fte_angle_if angles ();

	frame_to_euler_angles #(.COMPONENT_WIDTH(16), .CORDIC_STAGES(STAGES)) u_dut (
		.clk(clk), .arst_n(arst_n), .frame(frame.sink), .angles(angles.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	euler_t expected_angles[$];
	int errors;
	int src_idle, sink_idle;
	int wd_count;
	bit hold_request;
	int hold_left;
	logic [9:0] thr_copy;

	initial begin
		clk = 0;
	end
	always #2 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic bit is_small(longint a, longint b);
		longint ma, mb;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		return ((ma >>> GUARD_BITS) <= longint'(thr_copy)) &&
			((mb >>> GUARD_BITS) <= longint'(thr_copy));
	endfunction

	function automatic logic [31:0] cordic_atan2(longint a, longint b);
		logic [31:0] z;
		longint da, db;
		z = 0;
		if (a < 0) begin
			a = -a;
			b = -b;
			z = HALF_TURN;
		end
		for (int i = 0; i < STAGES; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (b >= 0) begin
				a += da; b -= db; z += ATAN_UNITS[i];
			end else begin
				a -= da; b += db; z -= ATAN_UNITS[i];
			end
		end
		return z;
	endfunction

	function automatic longint gain_scale(longint v);
		return (v * longint'(GAIN_COMP) + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
	endfunction

	function automatic void rotate_back(inout longint a, inout longint b,
			input logic [31:0] theta);
		longint z, da, db, ra, rb;
		ra = a;
		rb = b;
		if (is_small(ra, rb))
			return;
		z = longint'($signed(theta));
		if (z > 64'sh4000_0000 || z < -64'sh4000_0000) begin
			ra = -ra;
			rb = -rb;
			z += (z > 0) ? -(longint'(1) << 31) : (longint'(1) << 31);
		end
		for (int i = 0; i < STAGES; i++) begin
			da = rb >>> i;
			db = ra >>> i;
			if (z >= 0) begin
				ra -= da; rb += db; z -= longint'(ATAN_UNITS[i]);
			end else begin
				ra += da; rb -= db; z += longint'(ATAN_UNITS[i]);
			end
		end
		a = gain_scale(ra);
		b = gain_scale(rb);
	endfunction

	function automatic logic [15:0] to_binary_angle(logic [31:0] z);
		logic [31:0] t;
		t = z + OUT_ROUND;
		return t[31:16];
	endfunction

	function automatic euler_t predict_angles(frame_t f);
		longint fx, fy, fz, sx, sy, sz;
		logic [31:0] az, ay, ax, t;
		euler_t r;
		fx = longint'(f.fx) <<< GUARD_BITS;
		fy = longint'(f.fy) <<< GUARD_BITS;
		fz = longint'(f.fz) <<< GUARD_BITS;
		sx = longint'(f.sx) <<< GUARD_BITS;
		sy = longint'(f.sy) <<< GUARD_BITS;
		sz = longint'(f.sz) <<< GUARD_BITS;
		az = 0;
		ay = 0;
		ax = 0;
		if (!is_small(fx, fy)) begin
			az = cordic_atan2(fx, fy);
			rotate_back(fx, fy, 32'd0 - az);
			rotate_back(sx, sy, 32'd0 - az);
		end
		if (!is_small(fx, fz)) begin
			t = cordic_atan2(fx, fz);
			ay = 32'd0 - t;
			rotate_back(fx, fz, 32'd0 - t);
			rotate_back(sx, sz, 32'd0 - t);
		end
		if (!is_small(sy, sz))
			ax = cordic_atan2(sy, sz);
		r.ax = to_binary_angle(ax);
		r.ay = to_binary_angle(ay);
		r.az = to_binary_angle(az);
		return r;
	endfunction

	// ---------------- monitors ----------------
	always @(posedge clk) begin
		if (arst_n && frame.valid && frame.ready) begin
			frame_t f;
			f = {frame.first_x, frame.first_y, frame.first_z,
				frame.second_x, frame.second_y, frame.second_z};
			expected_angles.push_back(predict_angles(f));
		end
	end

	always @(posedge clk) begin
		if (arst_n && angles.valid && angles.ready) begin
			euler_t e;
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
					angles.angle_about_x, angles.angle_about_y, angles.angle_about_z);
				errors++;
			end else begin
				e = expected_angles.pop_front();
				if (angles.angle_about_x !== e.ax) begin
					$display("%0t: angle_about_x expected %0d actual %0d", $time,
						e.ax, angles.angle_about_x);
					errors++;
				end
				if (angles.angle_about_y !== e.ay) begin
					$display("%0t: angle_about_y expected %0d actual %0d", $time,
						e.ay, angles.angle_about_y);
					errors++;
				end
				if (angles.angle_about_z !== e.az) begin
					$display("%0t: angle_about_z expected %0d actual %0d", $time,
						e.az, angles.angle_about_z);
					errors++;
				end
			end
		end
	end

	// receiver, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			angles.ready <= 1'b0;
		end else begin
			angles.ready <= ($urandom_range(99) >= sink_idle);
		end
	end

	always @(posedge clk) begin
		if ((frame.valid && frame.ready) || (angles.valid && angles.ready))
			wd_count = 0;
		else
			wd_count++;
		if (wd_count >= WD_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic send_frame(frame_t f);
		if ($urandom_range(99) < src_idle) begin
			frame.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle);
		end
		frame.valid    <= 1'b1;
		frame.first_x  <= f.fx;
		frame.first_y  <= f.fy;
		frame.first_z  <= f.fz;
		frame.second_x <= f.sx;
		frame.second_y <= f.sy;
		frame.second_z <= f.sz;
		do
			@(posedge clk);
		while (!frame.ready);
	endtask

	task automatic drain;
		frame.valid <= 1'b0;
		@(posedge clk);
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_threshold(logic [9:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_NEAR_ZERO, 2'b00};
		pwdata  <= {22'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		thr_copy = value;
	endtask

	function automatic logic signed [15:0] rand_component();
		int mode;
		mode = $urandom_range(9);
		case (mode)
			0, 1: return 16'($urandom);
			2: return $signed(16'($urandom_range(2 * (int'(thr_copy) + 3)))) -
				$signed(16'(int'(thr_copy) + 3));
			3: return 16'sd0;
			default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
		endcase
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		f.fx = rand_component();
		f.fy = rand_component();
		f.fz = rand_component();
		f.sx = rand_component();
		f.sy = rand_component();
		f.sz = rand_component();
		return f;
	endfunction

	task automatic test_directed;
		frame_t list[$];
		list.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		list.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		list.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0});
		list.push_back('{16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0});
		list.push_back('{16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		list.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
		list.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384});
		list.push_back('{16'sd11585, 16'sd11585, 16'sd0, -16'sd11585, 16'sd11585, 16'sd0});
		list.push_back('{-16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'sd0, -16'sd16384});
		list.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
			-16'sd32768});
		list.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767});
		list.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
			16'sd32767});
		list.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
			-16'sd32768});
		list.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1});
		list.push_back('{16'sd0, 16'sd0, 16'sd5, 16'sd100, 16'sd0, 16'sd0});
		list.push_back('{-16'sd16384, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		list.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd1});
		list.push_back('{16'sd5, 16'sd3, 16'sd9000, 16'sd2, 16'sd7, -16'sd6});
		foreach (list[i])
			send_frame(list[i]);
		drain();
	endtask

	task automatic test_random(int count, bit with_hold);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == count / 3)
				hold_request = 1;
			send_frame(rand_frame());
		end
		drain();
	endtask

	task automatic test_threshold_sweep;
		write_threshold(10'd1023);
		test_directed();
		test_random(150, 0);
		write_threshold(10'd1);
		test_random(150, 0);
		write_threshold(10'($urandom_range(1023)));
		test_random(150, 0);
	endtask

	initial begin
		errors = 0;
		wd_count = 0;
		hold_request = 0;
		hold_left = 0;
		thr_copy = 0;
		src_idle = 25;
		sink_idle = 50;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frame.valid = 1'b0;
		frame.first_x = '0;
		frame.first_y = '0;
		frame.first_z = '0;
		frame.second_x = '0;
		frame.second_y = '0;
		frame.second_z = '0;
		angles.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_threshold(10'd0);
		test_random(350, 1);

		src_idle = 50;
		sink_idle = 25;
		test_threshold_sweep();

		src_idle = 0;
		sink_idle = 0;
		write_threshold(10'd0);
		test_random(300, 1);
		write_threshold(10'd300);
		test_random(250, 0);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
